// ===== rtl/core/ncb_pkg.sv =====
// shared types, constants and helpers for the cpu bus decoder
`timescale 1ns / 1ps
package ncb_pkg;

	localparam int RAM_MIRROR_SIZE_DEF = 2048;
	localparam int STORE_DEPTH         = 65536;
	localparam int STORE_AW            = 16;

	localparam logic [1:0] KIND_READ    = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_PRELOAD = 2'd2;

	localparam logic [15:0] PPU_BASE    = 16'h2000;
	localparam logic [15:0] DMA_ADDR    = 16'h4014;
	localparam logic [15:0] PAD_ADDR    = 16'h4016;
	localparam logic [15:0] PAD_HI_ADDR = 16'h4017;
	localparam logic [15:0] RAM_LIMIT   = 16'h1FFF;
	localparam logic [7:0]  PAD_HI_KEEP = 8'hC0;
	localparam logic [7:0]  FILL_BYTE   = 8'hFF;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        ppu_access;
		logic [2:0]  ppu_reg;
		logic        ppu_write;
		logic [7:0]  ppu_data;
		logic        dma_start;
		logic [7:0]  dma_page;
		logic        chr_update;
		logic [15:0] chr_offset;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic rd_done;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic need_read;
		logic space;
	} sts_t;

	// power-up contents of the store
	function automatic logic [7:0] preset_byte(input logic [15:0] addr);
		logic [7:0] b;
		b = FILL_BYTE;
		case (addr)
			16'h0008: b = 8'hF7;
			16'h0009: b = 8'hEF;
			16'h000A: b = 8'hDF;
			16'h000F: b = 8'hBF;
			default:  b = FILL_BYTE;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/ncb_acc_if.sv =====
// bus access channel
`timescale 1ns / 1ps
interface ncb_acc_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] address;
	logic [7:0]  data;
	logic [7:0]  buttons;

	modport source (output valid, kind, address, data, buttons, input ready);
	modport sink (input valid, kind, address, data, buttons, output ready);
endinterface

// ===== rtl/core/ncb_res_if.sv =====
// access result channel
`timescale 1ns / 1ps
interface ncb_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        ppu_access;
	logic [2:0]  ppu_reg;
	logic        ppu_write;
	logic [7:0]  ppu_data;
	logic        dma_start;
	logic [7:0]  dma_page;
	logic        chr_update;
	logic [15:0] chr_offset;

	modport source (output valid, read_data, ppu_access, ppu_reg, ppu_write, ppu_data,
		dma_start, dma_page, chr_update, chr_offset, input ready);
	modport sink (input valid, read_data, ppu_access, ppu_reg, ppu_write, ppu_data,
		dma_start, dma_page, chr_update, chr_offset, output ready);
endinterface

// ===== rtl/core/ncb_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module ncb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/ncb_ctrl.sv =====
// controller: store clearing pass, access acceptance and read wait
`timescale 1ns / 1ps
module ncb_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         acc_valid,
	output logic         acc_ready,
	input  ncb_pkg::sts_t sts,
	output ncb_pkg::cmd_t cmd
);
	import ncb_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		acc_ready    = (state_q == ST_IDLE) && sts.space;
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.accept   = acc_valid && acc_ready;
		cmd.rd_done  = (state_q == ST_READ);
		state_d      = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.accept && sts.need_read) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/core/ncb_datapath.sv =====
// datapath: address decode, controller port, byte store and result queue
`timescale 1ns / 1ps
module ncb_datapath #(
	parameter int RAM_MIRROR_SIZE = ncb_pkg::RAM_MIRROR_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ncb_acc_if.sink       acc,
	ncb_res_if.source     res,
	input  ncb_pkg::cmd_t cmd,
	output ncb_pkg::sts_t sts
);
	import ncb_pkg::*;

	localparam logic [15:0] MIRROR_MASK = 16'(RAM_MIRROR_SIZE - 1) & RAM_LIMIT;

	// store
	logic                ram_we;
	logic [STORE_AW-1:0] ram_waddr;
	logic [7:0]          ram_wdata;
	logic [STORE_AW-1:0] ram_raddr;
	logic [7:0]          ram_rdata;
	logic [STORE_AW-1:0] clr_addr_q;

	// controller port bytes held outside the store
	logic       pad_strobe_q, pad_strobe_d;
	logic [7:0] pad_shift_q, pad_shift_d;
	logic [7:0] pad_lat_q, pad_lat_d;
	logic [7:0] pad_hi_q, pad_hi_d;

	// result queue
	res_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	res_t       res_now, push_res;

	logic       is_wr, is_rd, is_ram, is_ppu, is_pad, is_hi, is_map;
	logic [1:0] bank;

	ncb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		is_wr  = (acc.kind == KIND_WRITE);
		is_rd  = (acc.kind == KIND_READ);
		is_ram = (acc.address[15:13] == 3'b000);
		is_ppu = (acc.address[15:13] == 3'b001);
		is_pad = (acc.address == PAD_ADDR);
		is_hi  = (acc.address == PAD_HI_ADDR);
		is_map = acc.address[15];
		bank   = acc.data[1:0];

		res_now       = '0;
		sts.need_read = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = acc.address;
		ram_wdata     = acc.data;
		ram_raddr     = acc.address;
		pad_strobe_d  = pad_strobe_q;
		pad_shift_d   = pad_shift_q;
		pad_lat_d     = pad_lat_q;
		pad_hi_d      = pad_hi_q;

		if (acc.kind == KIND_PRELOAD) begin
			if (is_pad) pad_lat_d = acc.data;
			else if (is_hi) pad_hi_d = acc.data;
			else ram_we = cmd.accept;
		end else if (is_wr || is_rd) begin
			if (is_ram) begin
				ram_waddr = acc.address & MIRROR_MASK;
				ram_raddr = acc.address & MIRROR_MASK;
				ram_we    = cmd.accept && is_wr;
				sts.need_read = is_rd;
			end else if (is_ppu) begin
				res_now.ppu_access = 1'b1;
				res_now.ppu_reg    = acc.address[2:0];
				res_now.ppu_write  = is_wr;
				res_now.ppu_data   = is_wr ? acc.data : 8'd0;
				ram_waddr          = PPU_BASE | {13'd0, acc.address[2:0]};
				ram_we             = cmd.accept && is_wr;
			end else if (is_pad) begin
				if (is_wr) begin
					pad_strobe_d = acc.data[0];
					if (acc.data[0]) begin
						pad_shift_d = acc.buttons;
						pad_lat_d   = {7'd0, acc.buttons[0]};
						pad_hi_d    = (pad_hi_q & PAD_HI_KEEP) | {7'd0, acc.buttons[0]};
					end
				end else if (!pad_strobe_q) begin
					pad_lat_d         = {7'd0, pad_shift_q[0]};
					pad_hi_d          = (pad_hi_q & PAD_HI_KEEP) | {7'd0, pad_shift_q[0]};
					pad_shift_d       = {1'b1, pad_shift_q[7:1]};
					res_now.read_data = {7'd0, pad_shift_q[0]};
				end else begin
					res_now.read_data = pad_lat_q;
				end
			end else if (is_map && is_wr) begin
				res_now.chr_update = 1'b1;
				// bank 0 sits at zero, others at (bank + 1) * 8K
				res_now.chr_offset = (bank == 2'd0) ? 16'd0 : {({1'b0, bank} + 3'd1), 13'd0};
			end else if (is_hi) begin
				if (is_wr) pad_hi_d = acc.data;
				else res_now.read_data = pad_hi_q;
			end else begin
				if (is_wr && acc.address == DMA_ADDR) begin
					res_now.dma_start = 1'b1;
					res_now.dma_page  = acc.data;
				end
				ram_we        = cmd.accept && is_wr;
				sts.need_read = is_rd;
			end
		end

		// clearing pass owns the write port
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = preset_byte(clr_addr_q);
		end

		push_res = res_now;
		if (cmd.rd_done) begin
			push_res           = '0;
			push_res.read_data = ram_rdata;
		end
		push = (cmd.accept && !sts.need_read) || cmd.rd_done;
		pop  = res.valid && res.ready;

		sts.clr_last = (clr_addr_q == STORE_AW'(STORE_DEPTH - 1));
		sts.space    = (cnt_q != 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			pad_strobe_q <= 1'b0;
			pad_shift_q  <= '0;
			pad_lat_q    <= FILL_BYTE;
			pad_hi_q     <= FILL_BYTE;
			wr_ptr_q     <= 1'b0;
			rd_ptr_q     <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cmd.clr_step) clr_addr_q <= clr_addr_q + STORE_AW'(1);
			if (cmd.accept) begin
				pad_strobe_q <= pad_strobe_d;
				pad_shift_q  <= pad_shift_d;
				pad_lat_q    <= pad_lat_d;
				pad_hi_q     <= pad_hi_d;
			end
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_res;
	end

	always_comb begin
		res.valid      = (cnt_q != 2'd0);
		res.read_data  = ent_q[rd_ptr_q].read_data;
		res.ppu_access = ent_q[rd_ptr_q].ppu_access;
		res.ppu_reg    = ent_q[rd_ptr_q].ppu_reg;
		res.ppu_write  = ent_q[rd_ptr_q].ppu_write;
		res.ppu_data   = ent_q[rd_ptr_q].ppu_data;
		res.dma_start  = ent_q[rd_ptr_q].dma_start;
		res.dma_page   = ent_q[rd_ptr_q].dma_page;
		res.chr_update = ent_q[rd_ptr_q].chr_update;
		res.chr_offset = ent_q[rd_ptr_q].chr_offset;
	end
endmodule

// ===== rtl/core/nes_cpu_bus_decoder.sv =====
// cpu bus decoder top level: controller, datapath and channel hookup
//
//   channel  dir  what one transfer carries
//   acc      in   kind, address, data, buttons of one bus access
//   res      out  read data, ppu forward, dma request, chr bank select
//
// each access gives exactly one result; results queue two deep
// a store read blocks the next access in the read state, as the store read port is registered
// after reset a clearing pass presets every store byte; no access is taken meanwhile
// a full result queue holds off further accesses until res takes a result
`timescale 1ns / 1ps
module nes_cpu_bus_decoder #(
	parameter int RAM_MIRROR_SIZE = ncb_pkg::RAM_MIRROR_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ncb_acc_if.sink   acc,
	ncb_res_if.source res
);
	import ncb_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic rdy;

	assign acc.ready = rdy;

	ncb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc.valid),
		.acc_ready (rdy),
		.sts       (sts),
		.cmd       (cmd)
	);

	ncb_datapath #(.RAM_MIRROR_SIZE(RAM_MIRROR_SIZE)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

// ===== verif/ncb_bus_checker.sv =====
// bus checker: shadows the cpu bus store and scores every result transfer
`timescale 1ns / 1ps
module ncb_bus_checker #(
	parameter int MIRROR_BYTES = ncb_pkg::RAM_MIRROR_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ncb_acc_if          acc,
	ncb_res_if          res,
	output int unsigned fail_count,
	output int unsigned pending
);
	import ncb_pkg::*;

	localparam logic [15:0] PPU_LAST    = 16'h3FFF;
	localparam logic [15:0] MAPPER_BASE = 16'h8000;
	localparam logic [15:0] CHR_STEP    = 16'h2000;
	localparam int          SHOWN_MAX   = 10;

	logic [7:0]  bus_mem [0:STORE_DEPTH-1];
	logic [7:0]  pad_bits;
	logic        pad_latched;
	res_t        expected_q[$];
	int unsigned result_no;

	// shadow store and controller port as they stand after reset
	function automatic void reset_shadow();
		for (int i = 0; i < STORE_DEPTH; i++)
			bus_mem[i] = FILL_BYTE;
		bus_mem[16'h0008] = 8'hF7;
		bus_mem[16'h0009] = 8'hEF;
		bus_mem[16'h000A] = 8'hDF;
		bus_mem[16'h000F] = 8'hBF;
		pad_bits    = '0;
		pad_latched = 1'b0;
	endfunction

	// controller bit shows up in 0x4016 and in the low bit of 0x4017
	function automatic void load_pad_bit(input logic b);
		bus_mem[PAD_ADDR]    = {7'd0, b};
		bus_mem[PAD_HI_ADDR] = (bus_mem[PAD_HI_ADDR] & PAD_HI_KEEP) | {7'd0, b};
	endfunction

	function automatic res_t predict_access(input logic [1:0] kind, input logic [15:0] addr,
		input logic [7:0] data, input logic [7:0] buttons);
		res_t        r;
		logic [15:0] ram_addr;
		logic [1:0]  bank;
		r = '0;
		if (kind == KIND_PRELOAD) begin
			bus_mem[addr] = data;
		end else if (kind == KIND_READ || kind == KIND_WRITE) begin
			if (addr <= RAM_LIMIT) begin
				ram_addr = addr & 16'(MIRROR_BYTES - 1) & RAM_LIMIT;
				if (kind == KIND_WRITE)
					bus_mem[ram_addr] = data;
				else
					r.read_data = bus_mem[ram_addr];
			end else if (addr <= PPU_LAST) begin
				// ppu read data come from outside, so read_data stays zero
				r.ppu_access = 1'b1;
				r.ppu_reg    = addr[2:0];
				if (kind == KIND_WRITE) begin
					r.ppu_write = 1'b1;
					r.ppu_data  = data;
					bus_mem[PPU_BASE | 16'(addr[2:0])] = data;
				end
			end else if (addr == PAD_ADDR) begin
				if (kind == KIND_WRITE) begin
					if (data[0]) begin
						pad_latched = 1'b1;
						pad_bits    = buttons;
						load_pad_bit(buttons[0]);
					end else begin
						pad_latched = 1'b0;
					end
				end else begin
					if (!pad_latched) begin
						load_pad_bit(pad_bits[0]);
						pad_bits = {1'b1, pad_bits[7:1]};
					end
					r.read_data = bus_mem[PAD_ADDR];
				end
			end else if (addr >= MAPPER_BASE && kind == KIND_WRITE) begin
				bank         = data[1:0];
				r.chr_update = 1'b1;
				r.chr_offset = (bank == 2'd0) ? 16'h0000 : CHR_STEP + 16'(bank) * CHR_STEP;
			end else if (kind == KIND_WRITE) begin
				if (addr == DMA_ADDR) begin
					r.dma_start = 1'b1;
					r.dma_page  = data;
				end
				bus_mem[addr] = data;
			end else begin
				r.read_data = bus_mem[addr];
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : score
		res_t  got;
		res_t  want;
		string bad;
		if (!arst_n) begin
			reset_shadow();
		end else begin
			if (acc.valid && acc.ready)
				expected_q.insert(expected_q.size(), predict_access(acc.kind, acc.address,
					acc.data, acc.buttons));
			if (res.valid && res.ready) begin
				got = {res.read_data, res.ppu_access, res.ppu_reg, res.ppu_write, res.ppu_data,
					res.dma_start, res.dma_page, res.chr_update, res.chr_offset};
				result_no++;
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOWN_MAX)
						$display("result %0d arrived with no access waiting for it", result_no);
				end else begin
					want = expected_q.pop_front();
					bad  = "";
					if (got.read_data !== want.read_data)   bad = {bad, " read_data"};
					if (got.ppu_access !== want.ppu_access) bad = {bad, " ppu_access"};
					if (got.ppu_reg !== want.ppu_reg)       bad = {bad, " ppu_reg"};
					if (got.ppu_write !== want.ppu_write)   bad = {bad, " ppu_write"};
					if (got.ppu_data !== want.ppu_data)     bad = {bad, " ppu_data"};
					if (got.dma_start !== want.dma_start)   bad = {bad, " dma_start"};
					if (got.dma_page !== want.dma_page)     bad = {bad, " dma_page"};
					if (got.chr_update !== want.chr_update) bad = {bad, " chr_update"};
					if (got.chr_offset !== want.chr_offset) bad = {bad, " chr_offset"};
					if (bad != "") begin
						fail_count++;
						if (fail_count <= SHOWN_MAX) begin
							$display("result %0d mismatch in%s", result_no, bad);
							$display("  expected rd=%h ppu=%b/%0d/%b/%h dma=%b/%h chr=%b/%h",
								want.read_data, want.ppu_access, want.ppu_reg, want.ppu_write,
								want.ppu_data, want.dma_start, want.dma_page, want.chr_update,
								want.chr_offset);
							$display("  actual   rd=%h ppu=%b/%0d/%b/%h dma=%b/%h chr=%b/%h",
								got.read_data, got.ppu_access, got.ppu_reg, got.ppu_write,
								got.ppu_data, got.dma_start, got.dma_page, got.chr_update,
								got.chr_offset);
						end
					end
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

// ===== verif/tb_nes_cpu_bus_decoder.sv =====
// testbench top: clock, reset, bus access stimulus and the verdict
`timescale 1ns / 1ps
module tb_nes_cpu_bus_decoder;
	import ncb_pkg::*;

	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         ACCESS_COUNT = 1950;
	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         DRAIN_CYCLES = 8;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned accesses_sent = 0;
	int unsigned cycle_count   = 0;
	int unsigned tx_odds       = 0;
	int unsigned rx_odds       = 0;
	int unsigned rx_hold       = 0;

	ncb_acc_if acc_ch ();
	ncb_res_if res_ch ();

	nes_cpu_bus_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc_ch),
		.res    (res_ch)
	);

	ncb_bus_checker bus_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side stalls at random while rx_odds is nonzero
	always @(posedge clk) begin
		if (rx_hold != 0)
			rx_hold = rx_hold - 1;
		else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1)
			rx_hold = $urandom_range(1, 17);
		res_ch.ready <= (rx_hold == 0);
	end

	task automatic issue_access(input logic [1:0] kind, input logic [15:0] addr,
		input logic [7:0] data, input logic [7:0] buttons);
		if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
			acc_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		acc_ch.valid   <= 1'b1;
		acc_ch.kind    <= kind;
		acc_ch.address <= addr;
		acc_ch.data    <= data;
		acc_ch.buttons <= buttons;
		@(posedge clk);
		while (!acc_ch.ready) @(posedge clk);
		accesses_sent++;
	endtask

	task automatic random_traffic();
		int unsigned pick;
		logic [15:0] addr;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			// ram: half the time a small window in all four mirrors so reads hit earlier writes
			if ($urandom_range(0, 1))
				addr = 16'($urandom_range(0, 31)) | 16'($urandom_range(0, 3) << 11);
			else
				addr = 16'($urandom_range(0, 16'h1FFF));
			issue_access(2'($urandom_range(0, 1)), addr, 8'($urandom), 8'($urandom));
		end else if (pick < 50) begin
			issue_access(2'($urandom_range(0, 1)), 16'($urandom_range(16'h2000, 16'h3FFF)),
				8'($urandom), 8'($urandom));
		end else if (pick < 63) begin
			// controller: strobe high, maybe a read while latched, strobe low, then shift out
			issue_access(KIND_WRITE, PAD_ADDR, 8'($urandom) | 8'h01, 8'($urandom));
			if ($urandom_range(0, 3) == 0)
				issue_access(KIND_READ, PAD_ADDR, 8'($urandom), 8'($urandom));
			issue_access(KIND_WRITE, PAD_ADDR, 8'($urandom) & 8'hFE, 8'($urandom));
			repeat ($urandom_range(1, 10))
				issue_access(KIND_READ, PAD_ADDR, 8'($urandom), 8'($urandom));
		end else if (pick < 68) begin
			issue_access(KIND_WRITE, DMA_ADDR, 8'($urandom), 8'($urandom));
			if ($urandom_range(0, 1))
				issue_access(KIND_READ, DMA_ADDR, 8'($urandom), 8'($urandom));
		end else if (pick < 76) begin
			issue_access(2'($urandom_range(0, 1)), 16'($urandom_range(16'h8000, 16'hFFFF)),
				8'($urandom), 8'($urandom));
		end else if (pick < 86) begin
			addr = 16'($urandom_range(16'h4000, 16'h7FFF));
			if ($urandom_range(0, 3) == 0)
				addr = PAD_HI_ADDR;
			issue_access(KIND_WRITE, addr, 8'($urandom), 8'($urandom));
			issue_access(KIND_READ, addr, 8'($urandom), 8'($urandom));
		end else if (pick < 94) begin
			addr = 16'($urandom);
			issue_access(KIND_PRELOAD, addr, 8'($urandom), 8'($urandom));
			issue_access(KIND_READ, addr, 8'($urandom), 8'($urandom));
		end else if (pick < 96) begin
			issue_access(KIND_UNUSED, 16'($urandom), 8'($urandom), 8'($urandom));
		end else begin
			issue_access(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		acc_ch.valid   <= 1'b0;
		acc_ch.kind    <= KIND_READ;
		acc_ch.address <= '0;
		acc_ch.data    <= '0;
		acc_ch.buttons <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// preset bytes, ram mirror, ppu, dma, controller, mapper, preload, unused kind
		issue_access(KIND_READ, 16'h0008, 8'h00, 8'h00);
		issue_access(KIND_READ, 16'h0009, 8'hFF, 8'hFF);
		issue_access(KIND_READ, 16'h000A, 8'h00, 8'h00);
		issue_access(KIND_READ, 16'h000F, 8'h00, 8'h00);
		issue_access(KIND_WRITE, 16'h07FF, 8'h00, 8'hFF);
		issue_access(KIND_READ, 16'h1FFF, 8'hFF, 8'h00);
		issue_access(KIND_READ, 16'h2000, 8'hFF, 8'h00);
		issue_access(KIND_WRITE, 16'h3FFF, 8'hA5, 8'h00);
		issue_access(KIND_WRITE, DMA_ADDR, 8'hFF, 8'h00);
		issue_access(KIND_READ, DMA_ADDR, 8'h00, 8'h00);
		issue_access(KIND_WRITE, PAD_ADDR, 8'h01, 8'hA5);
		issue_access(KIND_READ, PAD_ADDR, 8'h00, 8'h00);
		issue_access(KIND_WRITE, PAD_ADDR, 8'hFE, 8'hFF);
		issue_access(KIND_READ, PAD_ADDR, 8'h00, 8'h00);
		issue_access(KIND_READ, PAD_ADDR, 8'h00, 8'h00);
		issue_access(KIND_READ, PAD_ADDR, 8'h00, 8'h00);
		issue_access(KIND_READ, PAD_HI_ADDR, 8'h00, 8'h00);
		issue_access(KIND_WRITE, 16'h8000, 8'h00, 8'h00);
		issue_access(KIND_WRITE, 16'hFFFF, 8'h01, 8'h00);
		issue_access(KIND_WRITE, 16'hC000, 8'h02, 8'h00);
		issue_access(KIND_WRITE, 16'h8001, 8'hFF, 8'h00);
		issue_access(KIND_READ, 16'h8000, 8'h00, 8'h00);
		issue_access(KIND_PRELOAD, 16'hFFFC, 8'h5A, 8'h00);
		issue_access(KIND_READ, 16'hFFFC, 8'h00, 8'h00);
		issue_access(KIND_UNUSED, 16'h1234, 8'hFF, 8'hFF);

		tx_odds = 8;
		rx_odds = 8;
		while (accesses_sent < 600) random_traffic();
		tx_odds = 0;
		rx_odds = 0;
		while (accesses_sent < 1100) random_traffic();

		// hold the bus until every outstanding result is back
		acc_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);

		tx_odds = 4;
		rx_odds = 4;
		while (accesses_sent < 1700) random_traffic();
		tx_odds = 0;
		rx_odds = 0;
		while (accesses_sent < ACCESS_COUNT) random_traffic();

		acc_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
